// ===== design/serial_mouse_packet_decoder_top_macros.svh =====
// Assertion macros for the serial mouse packet decoder.
// Used by the port checker; no other dependencies.
`ifndef SERIAL_MOUSE_PACKET_DECODER_TOP_MACROS_SVH
`define SERIAL_MOUSE_PACKET_DECODER_TOP_MACROS_SVH

// Same-cycle implication, off during reset.
`define SPM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define SPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication, also checked across reset.
`define SPM_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/spm_pkg.sv =====
// Shared types, constants and framing table for the serial mouse packet decoder.
// No dependencies.
package spm_pkg;

  localparam int unsigned POS_W       = 15;
  localparam int unsigned BTN_W       = 3;
  localparam int unsigned MODE_W      = 3;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 15;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned RES_W       = 2 * POS_W + BTN_W + 1;
  localparam int unsigned OUT_TDATA_W = ((RES_W + 7) / 8) * 8;
  localparam int unsigned DEC_BYTES   = 5;

  localparam logic [MODE_W-1:0] MODE_SEVEN_BIT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_EIGHT_3B  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_EIGHT_5B  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SIGN_A    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SIGN_B    = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE         = 3'd0,
    CFG_BOUND_LEFT   = 3'd1,
    CFG_BOUND_TOP    = 3'd2,
    CFG_BOUND_RIGHT  = 3'd3,
    CFG_BOUND_BOTTOM = 3'd4,
    CFG_LOAD_X       = 3'd5,
    CFG_LOAD_Y       = 3'd6
  } cfg_idx_e;

  localparam logic [POS_W-1:0] RST_BOUND_LEFT   = 15'd0;
  localparam logic [POS_W-1:0] RST_BOUND_TOP    = 15'd0;
  localparam logic [POS_W-1:0] RST_BOUND_RIGHT  = 15'd639;
  localparam logic [POS_W-1:0] RST_BOUND_BOTTOM = 15'd399;
  localparam logic [POS_W-1:0] RST_LOAD_X       = 15'd320;
  localparam logic [POS_W-1:0] RST_LOAD_Y       = 15'd320;

  localparam logic [7:0] BYTE_BREAK = 8'h80;

  typedef struct packed {
    logic [7:0] hmask;
    logic [7:0] htest;
    logic [7:0] dmask;
    logic [7:0] dtest;
    logic [2:0] lmin;
    logic [2:0] lmax;
  } frame_t;

  // Gathered packet as seen by the decoder.
  typedef struct packed {
    logic                      emit;
    logic                      mid_ok;
    logic [DEC_BYTES-1:0][7:0] pb;
  } spm_pkt_t;

  // Result item; pos_x in the low bits.
  typedef struct packed {
    logic             moved;
    logic [BTN_W-1:0] button_bits;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_x;
  } spm_res_t;

  function automatic frame_t frame_of(logic [MODE_W-1:0] mode);
    frame_t f;
    case (mode)
      MODE_EIGHT_3B: f = '{8'hf8, 8'h80, 8'h00, 8'h00, 3'd3, 3'd3};
      MODE_EIGHT_5B: f = '{8'hf8, 8'h80, 8'h00, 8'h00, 3'd5, 3'd5};
      MODE_SIGN_A:   f = '{8'he0, 8'h80, 8'h80, 8'h00, 3'd3, 3'd3};
      MODE_SIGN_B:   f = '{8'he0, 8'h80, 8'h80, 8'h00, 3'd3, 3'd3};
      default:       f = '{8'h40, 8'h40, 8'h40, 8'h00, 3'd3, 3'd4};
    endcase
    return f;
  endfunction

endpackage

// ===== design/spm_framer.sv =====
// Packet framer: header hunt, byte count and packet store.
// Depends on spm_pkg.
module spm_framer #(
  parameter int unsigned MAX_PACKET_BYTES = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic [7:0]                    byte_i,
  input  logic [spm_pkg::MODE_W-1:0]    mode_i,
  output spm_pkg::spm_pkt_t             pkt_o
);
  import spm_pkg::*;

  localparam int unsigned CW = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_PACKET_BYTES);

  logic [CW-1:0] cnt_q, cnt_d;
  logic [7:0]    store_q [MAX_PACKET_BYTES];

  frame_t        f;
  logic          hdr_ok, bad, hunting, restart, wr_en, full;
  logic [CW-1:0] cnt_inc, dec_cnt, lmin_w, lmax_w;

  always_comb begin
    f       = frame_of(mode_i);
    lmin_w  = CW'(f.lmin);
    lmax_w  = CW'(f.lmax);
    hdr_ok  = (byte_i & f.hmask) == f.htest;
    bad     = ((byte_i & f.dmask) != f.dtest) || (byte_i == BYTE_BREAK);
    hunting = cnt_q == '0;
    restart = hunting || bad;
    cnt_inc = cnt_q + CW'(1);
    full    = (cnt_inc >= lmax_w) || (cnt_inc >= MAX_C);
    wr_en   = !restart && (cnt_q < MAX_C);
    dec_cnt = bad ? cnt_q : cnt_inc;

    pkt_o.emit   = !hunting && (bad ? (cnt_q >= lmin_w) : full);
    pkt_o.mid_ok = dec_cnt > lmin_w;
    for (int i = 0; i < DEC_BYTES; i++) begin
      pkt_o.pb[i] = (wr_en && cnt_q == CW'(i)) ? byte_i : store_q[i];
    end

    if (restart) begin
      cnt_d = hdr_ok ? CW'(1) : '0;
    end else begin
      cnt_d = full ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (adv_i) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_PACKET_BYTES; i++) begin
      if (adv_i && ((restart && hdr_ok && i == 0) || (wr_en && cnt_q == CW'(i)))) begin
        store_q[i] <= byte_i;
      end
    end
  end

endmodule

// ===== design/spm_tracker.sv =====
// Packet decode per protocol, offset and clamp, pointer position registers.
// Depends on spm_pkg.
module spm_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  spm_pkg::spm_pkt_t             pkt_i,
  input  logic [spm_pkg::MODE_W-1:0]    mode_i,
  input  logic [spm_pkg::POS_W-1:0]     bound_left_i,
  input  logic [spm_pkg::POS_W-1:0]     bound_top_i,
  input  logic [spm_pkg::POS_W-1:0]     bound_right_i,
  input  logic [spm_pkg::POS_W-1:0]     bound_bottom_i,
  input  logic                          load_x_we_i,
  input  logic                          load_y_we_i,
  input  logic [spm_pkg::POS_W-1:0]     load_val_i,
  output spm_pkg::spm_res_t             res_o
);
  import spm_pkg::*;

  localparam int unsigned SW = POS_W + 2;

  logic [POS_W-1:0] cur_x_q, cur_y_q, cur_x_d, cur_y_d;
  logic [7:0]       b0, b1, b2, b3, b4, dx, dy;
  logic [2:0]       idx;
  logic [BTN_W-1:0] btn;
  logic             moved;

  // index bit0 right, bit1 middle, bit2 left
  function automatic logic [BTN_W-1:0] btn_remap(logic [2:0] i);
    return {i[1], i[0], i[2]};
  endfunction

  function automatic logic [POS_W-1:0] clamp_axis(logic [POS_W-1:0] pos, logic [7:0] off,
                                                   logic [POS_W-1:0] lo, logic [POS_W-1:0] hi);
    logic signed [SW-1:0] n;
    n = $signed({2'b00, pos}) + $signed({{(SW-8){off[7]}}, off});
    if (n < $signed({2'b00, lo})) n = $signed({2'b00, lo});
    if (n > $signed({2'b00, hi})) n = $signed({2'b00, hi});
    return n[POS_W-1:0];
  endfunction

  always_comb begin
    b0  = pkt_i.pb[0];
    b1  = pkt_i.pb[1];
    b2  = pkt_i.pb[2];
    b3  = pkt_i.pb[3];
    b4  = pkt_i.pb[4];
    idx = '0;
    case (mode_i)
      MODE_EIGHT_3B: begin
        idx = ~b0[2:0];
        btn = btn_remap(idx);
        dx  = b1;
        dy  = 8'd0 - b2;
      end
      MODE_EIGHT_5B: begin
        idx = ~b0[2:0];
        btn = btn_remap(idx);
        dx  = b1 + b3;
        dy  = 8'd0 - (b2 + b4);
      end
      MODE_SIGN_A, MODE_SIGN_B: begin
        idx = b0[2:0];
        btn = btn_remap(idx);
        dx  = b0[4] ? b1 : 8'd0 - b1;
        dy  = b0[3] ? 8'd0 - b2 : b2;
      end
      default: begin
        btn = {pkt_i.mid_ok & b3[5], b0[4], b0[5]};
        dx  = {b0[1:0], b1[5:0]};
        dy  = {b0[3:2], b2[5:0]};
      end
    endcase

    moved   = (dx != '0) || (dy != '0);
    cur_x_d = moved ? clamp_axis(cur_x_q, dx, bound_left_i, bound_right_i) : cur_x_q;
    cur_y_d = moved ? clamp_axis(cur_y_q, dy, bound_top_i, bound_bottom_i) : cur_y_q;

    res_o.moved       = moved;
    res_o.button_bits = btn;
    res_o.pos_x       = cur_x_d;
    res_o.pos_y       = cur_y_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= RST_LOAD_X;
      cur_y_q <= RST_LOAD_Y;
    end else begin
      if (load_x_we_i) begin
        cur_x_q <= load_val_i;
      end else if (adv_i && pkt_i.emit) begin
        cur_x_q <= cur_x_d;
      end
      if (load_y_we_i) begin
        cur_y_q <= load_val_i;
      end else if (adv_i && pkt_i.emit) begin
        cur_y_q <= cur_y_d;
      end
    end
  end

endmodule

// ===== design/serial_mouse_packet_decoder_top.sv =====
// Serial mouse packet decoder top: input register, framer, tracker, result register.
// Depends on spm_pkg, spm_framer, spm_tracker.
//
//   Channel  Dir  Payload                                        Handshake
//   s_axis   in   tdata[7:0] rx_byte                             tvalid/tready
//   m_axis   out  tdata[39:0] pos_x,pos_y,button_bits,moved      tvalid/tready
//   cfg      in   cfg_idx_i register index, cfg_wdata_i value    cfg_we_i, no stall
//
// One byte per cycle unless a held result stalls; a byte waits in the input
// register and its result, if any, is registered into the result register.
// Reset (async, active low) clears the byte count and both valid flags, sets the
// config registers to their defaults and the position to its reset load value.
// A held result stalls the input register; the input side keeps flowing while
// the result is taken in the same cycle.
module serial_mouse_packet_decoder_top #(
  parameter int unsigned MAX_PACKET_BYTES = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [spm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [7:0] rx_byte
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [spm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [14:0] pos_x, [29:15] pos_y,
                                                              // [32:30] button_bits, [33] moved
  input  logic                                cfg_we_i,
  input  logic [spm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [spm_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import spm_pkg::*;

  logic              in_valid_q, out_valid_q, adv;
  logic [7:0]        in_byte_q;
  spm_res_t          out_q, res;
  spm_pkt_t          pkt;
  logic [MODE_W-1:0] mode_q;
  logic [POS_W-1:0]  bound_left_q, bound_top_q, bound_right_q, bound_bottom_q;
  logic              load_x_we, load_y_we;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, out_q};
  assign load_x_we     = cfg_we_i && (cfg_idx_i == CFG_LOAD_X);
  assign load_y_we     = cfg_we_i && (cfg_idx_i == CFG_LOAD_Y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_SEVEN_BIT;
      bound_left_q   <= RST_BOUND_LEFT;
      bound_top_q    <= RST_BOUND_TOP;
      bound_right_q  <= RST_BOUND_RIGHT;
      bound_bottom_q <= RST_BOUND_BOTTOM;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:         mode_q         <= cfg_wdata_i[MODE_W-1:0];
        CFG_BOUND_LEFT:   bound_left_q   <= cfg_wdata_i[POS_W-1:0];
        CFG_BOUND_TOP:    bound_top_q    <= cfg_wdata_i[POS_W-1:0];
        CFG_BOUND_RIGHT:  bound_right_q  <= cfg_wdata_i[POS_W-1:0];
        CFG_BOUND_BOTTOM: bound_bottom_q <= cfg_wdata_i[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv && pkt.emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
    if (adv && pkt.emit) begin
      out_q <= res;
    end
  end

  spm_framer #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_framer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .byte_i (in_byte_q),
    .mode_i (mode_q),
    .pkt_o  (pkt)
  );

  spm_tracker u_tracker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .pkt_i          (pkt),
    .mode_i         (mode_q),
    .bound_left_i   (bound_left_q),
    .bound_top_i    (bound_top_q),
    .bound_right_i  (bound_right_q),
    .bound_bottom_i (bound_bottom_q),
    .load_x_we_i    (load_x_we),
    .load_y_we_i    (load_y_we),
    .load_val_i     (cfg_wdata_i[POS_W-1:0]),
    .res_o          (res)
  );

endmodule

// ===== design/spm_checker.sv =====
// Port-level checks for the serial mouse packet decoder, bound to the top level.
// Depends on spm_pkg and serial_mouse_packet_decoder_top_macros.svh.
`include "serial_mouse_packet_decoder_top_macros.svh"

module spm_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [spm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import spm_pkg::*;

  `SPM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
  `SPM_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")
  `SPM_ASSERT_NOW(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[OUT_TDATA_W-1:RES_W] == '0, "tdata padding not zero")
  `SPM_ASSERT_NEXT_ALWAYS(a_rst_quiet, clk_i, !rst_ni, !m_axis_tvalid, "result valid right after reset")
  `SPM_ASSERT_NEXT_ALWAYS(a_rst_ready, clk_i, !rst_ni, !s_axis_tvalid || s_axis_tready, "input transfer stalled right after reset")

endmodule

bind serial_mouse_packet_decoder_top spm_checker u_spm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/tb.sv =====
// Testbench for serial_mouse_packet_decoder_top: streams mouse bytes through the block under
// random sender and receiver idling, and checks each position report against a cycle-free model.
// Depends on spm_pkg and the decoder RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spm_pkg::*;

  localparam int PKT_MAX      = 5;
  localparam int SETTLE       = 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int RAND_PHASES  = 16;
  localparam int PHASE_BYTES  = 100;

  class mouse_track_sb;
    typedef struct {
      logic [7:0]  hmask;
      logic [7:0]  htest;
      logic [7:0]  dmask;
      logic [7:0]  dtest;
      int unsigned lmin;
      int unsigned lmax;
    } framing_t;

    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  box_l, box_t, box_r, box_b;
    logic [POS_W-1:0]  ptr_x, ptr_y;
    logic [7:0]        pkt [PKT_MAX];
    int unsigned       nbytes;
    spm_res_t          reports[$];
    int unsigned       errors;

    function new();
      mode   = MODE_SEVEN_BIT;
      box_l  = RST_BOUND_LEFT;
      box_t  = RST_BOUND_TOP;
      box_r  = RST_BOUND_RIGHT;
      box_b  = RST_BOUND_BOTTOM;
      ptr_x  = RST_LOAD_X;
      ptr_y  = RST_LOAD_Y;
      nbytes = 0;
      errors = 0;
      foreach (pkt[i]) pkt[i] = '0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_MODE:         mode = v[MODE_W-1:0];
        CFG_BOUND_LEFT:   box_l = v;
        CFG_BOUND_TOP:    box_t = v;
        CFG_BOUND_RIGHT:  box_r = v;
        CFG_BOUND_BOTTOM: box_b = v;
        CFG_LOAD_X:       ptr_x = v;
        CFG_LOAD_Y:       ptr_y = v;
        default: ;
      endcase
    endfunction

    function framing_t framing();
      framing_t f;
      case (mode)
        MODE_EIGHT_3B:            f = '{8'hf8, 8'h80, 8'h00, 8'h00, 3, 3};
        MODE_EIGHT_5B:            f = '{8'hf8, 8'h80, 8'h00, 8'h00, 5, 5};
        MODE_SIGN_A, MODE_SIGN_B: f = '{8'he0, 8'h80, 8'h80, 8'h00, 3, 3};
        default:                  f = '{8'h40, 8'h40, 8'h40, 8'h00, 3, 4};
      endcase
      return f;
    endfunction

    function int sx8(logic [7:0] v);
      return int'($signed(v));
    endfunction

    function int wrap8(int v);
      logic [7:0] t;
      t = v[7:0];
      return sx8(t);
    endfunction

    // index bit0 -> right, bit1 -> middle, bit2 -> left
    function logic [2:0] remap_btn(logic [2:0] ix);
      return {ix[1], ix[0], ix[2]};
    endfunction

    function logic [POS_W-1:0] clamp_axis(logic [POS_W-1:0] pos, int off,
                                          logic [POS_W-1:0] lo, logic [POS_W-1:0] hi);
      int n;
      n = int'(pos) + off;
      if (n < int'(lo)) n = int'(lo);
      if (n > int'(hi)) n = int'(hi);
      return n[POS_W-1:0];
    endfunction

    function void decode_packet(int unsigned cnt);
      framing_t         f;
      logic [BTN_W-1:0] btn;
      int               dx, dy;
      logic [7:0]       b0, b1, b2, b3, b4;
      spm_res_t         r;
      f  = framing();
      b0 = pkt[0];
      b1 = pkt[1];
      b2 = pkt[2];
      b3 = pkt[3];
      b4 = pkt[4];
      case (mode)
        MODE_EIGHT_3B: begin
          btn = remap_btn(~b0[2:0]);
          dx  = sx8(b1);
          dy  = wrap8(-sx8(b2));
        end
        MODE_EIGHT_5B: begin
          btn = remap_btn(~b0[2:0]);
          dx  = wrap8(sx8(b1) + sx8(b3));
          dy  = wrap8(-(sx8(b2) + sx8(b4)));
        end
        MODE_SIGN_A, MODE_SIGN_B: begin
          btn = remap_btn(b0[2:0]);
          dx  = b0[4] ? sx8(b1) : wrap8(-int'(b1));
          dy  = b0[3] ? wrap8(-int'(b2)) : sx8(b2);
        end
        default: begin
          btn = {(cnt > f.lmin) ? b3[5] : 1'b0, b0[4], b0[5]};
          dx  = sx8({b0[1:0], b1[5:0]});
          dy  = sx8({b0[3:2], b2[5:0]});
        end
      endcase
      if (dx != 0 || dy != 0) begin
        ptr_x = clamp_axis(ptr_x, dx, box_l, box_r);
        ptr_y = clamp_axis(ptr_y, dy, box_t, box_b);
      end
      r.pos_x       = ptr_x;
      r.pos_y       = ptr_y;
      r.button_bits = btn;
      r.moved       = (dx != 0 || dy != 0);
      reports.push_back(r);
    endfunction

    function void hunt(logic [7:0] b);
      framing_t f;
      f = framing();
      if ((b & f.hmask) == f.htest) begin
        pkt[0] = b;
        nbytes = 1;
      end else begin
        nbytes = 0;
      end
    endfunction

    function void take_byte(logic [7:0] b);
      framing_t f;
      f = framing();
      if (nbytes == 0) begin
        hunt(b);
        return;
      end
      if ((b & f.dmask) != f.dtest || b == BYTE_BREAK) begin
        if (nbytes >= f.lmin) decode_packet(nbytes);
        hunt(b);
        return;
      end
      if (nbytes < PKT_MAX) pkt[nbytes] = b;
      nbytes++;
      if (nbytes >= f.lmax || nbytes >= PKT_MAX) begin
        decode_packet(nbytes);
        nbytes = 0;
      end
    endfunction

    function void check_report(logic [OUT_TDATA_W-1:0] data);
      spm_res_t got, want;
      got = data[RES_W-1:0];
      if (reports.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected report: x=%0d y=%0d btn=%0d moved=%0d",
                   got.pos_x, got.pos_y, got.button_bits, got.moved);
        return;
      end
      want = reports.pop_front();
      if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
          got.button_bits !== want.button_bits || got.moved !== want.moved) begin
        errors++;
        if (errors <= 10)
          $display("report mismatch: expected x=%0d y=%0d btn=%0d moved=%0d, got x=%0d y=%0d btn=%0d moved=%0d",
                   want.pos_x, want.pos_y, want.button_bits, want.moved,
                   got.pos_x, got.pos_y, got.button_bits, got.moved);
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;

  mouse_track_sb sb = new();
  bit            no_idle;
  int            sent_bytes;

  serial_mouse_packet_decoder_top #(
    .MAX_PACKET_BYTES(PKT_MAX)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int gap_draw();
    return no_idle ? 0 : int'($urandom_range(0, 8));
  endfunction

  // all driving tasks start and end at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = gap_draw();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_byte(b);
    sent_bytes++;
    @(negedge clk_i);
  endtask

  task automatic send_seq(input logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i]);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.reports.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, v);
    @(negedge clk_i);
  endtask

  task automatic set_box(input logic [POS_W-1:0] l, t, r, b);
    write_reg(CFG_BOUND_LEFT, l);
    write_reg(CFG_BOUND_TOP, t);
    write_reg(CFG_BOUND_RIGHT, r);
    write_reg(CFG_BOUND_BOTTOM, b);
  endtask

  task automatic set_load(input logic [POS_W-1:0] x, y);
    write_reg(CFG_LOAD_X, x);
    write_reg(CFG_LOAD_Y, y);
  endtask

  task automatic pick_config();
    logic [MODE_W-1:0] m;
    logic [POS_W-1:0]  l, t, r, b, x, y;
    m = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
    write_reg(CFG_MODE, {12'($urandom), m});
    case ($urandom_range(0, 3))
      0: begin
        l = 15'($urandom_range(0, 1000));
        t = 15'($urandom_range(0, 1000));
        r = l + 15'($urandom_range(0, 2000));
        b = t + 15'($urandom_range(0, 2000));
      end
      1: begin
        l = '0;
        t = '0;
        r = '1;
        b = '1;
      end
      2: begin
        l = 15'($urandom_range(1000, 32767));
        t = 15'($urandom_range(1000, 32767));
        r = 15'($urandom_range(0, 999));
        b = 15'($urandom_range(0, 999));
      end
      default: begin
        l = 15'($urandom);
        t = 15'($urandom);
        r = l;
        b = t;
      end
    endcase
    set_box(l, t, r, b);
    x = ($urandom_range(0, 7) == 0) ? 15'($urandom) : 15'($urandom_range(l, r));
    y = ($urandom_range(0, 7) == 0) ? 15'($urandom) : 15'($urandom_range(t, b));
    set_load(x, y);
  endtask

  function automatic logic [7:0] data_byte();
    logic [7:0] d;
    d = 8'($urandom);
    case (sb.mode)
      MODE_SIGN_A, MODE_SIGN_B:     d[7] = 1'b0;
      MODE_EIGHT_3B, MODE_EIGHT_5B: if (d == BYTE_BREAK) d[0] = 1'b1;
      default: begin
        d[6] = 1'b0;
        if (d == BYTE_BREAK) d[0] = 1'b1;
      end
    endcase
    return d;
  endfunction

  // well-formed packet for the current mode; a cut one stops early on a break byte
  task automatic send_packet(input bit cut);
    int ndata;
    case (sb.mode)
      MODE_EIGHT_3B, MODE_EIGHT_5B: begin
        send_byte({5'b10000, 3'($urandom)});
        ndata = (sb.mode == MODE_EIGHT_3B) ? 2 : 4;
      end
      MODE_SIGN_A, MODE_SIGN_B: begin
        send_byte({3'b100, 5'($urandom)});
        ndata = 2;
      end
      default: begin
        send_byte({1'($urandom), 1'b1, 6'($urandom)});
        ndata = $urandom_range(2, 3);
      end
    endcase
    if (cut) ndata = 1;
    repeat (ndata) send_byte(data_byte());
    if (cut) send_byte(BYTE_BREAK);
  endtask

  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = gap_draw();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_report(m_axis_tdata);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int phase_end;
    int pick;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_MODE;
    cfg_wdata_i   = '0;
    no_idle       = 1'b0;
    sent_bytes    = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // 7-bit protocol: middle-button 4th byte, break byte ending a full packet,
    // header ending a packet, zero offset, short packet left open across a mode change
    send_seq('{8'h7F, 8'h3F, 8'h3F, 8'h20,
               8'h43, 8'h3F, 8'h00, 8'h80,
               8'h4A, 8'h00, 8'h00, 8'hC0, 8'h00, 8'h00, 8'h80,
               8'h4C, 8'h01});
    drain();
    write_reg(CFG_MODE, {12'hFFF, MODE_EIGHT_5B});
    send_seq('{8'h05, 8'hFF, 8'h7F});

    // inverted box at the extremes
    drain();
    write_reg(CFG_MODE, {12'h000, MODE_EIGHT_3B});
    set_box(15'h7FFF, 15'h7FFF, 15'h0000, 15'h0000);
    set_load(15'h0000, 15'h7FFF);
    send_seq('{8'h80, 8'h7F, 8'h81});

    drain();
    write_reg(CFG_MODE, {12'h000, MODE_SIGN_A});
    set_box(15'h0000, 15'h0000, 15'h7FFF, 15'h7FFF);
    set_load(15'h7FFF, 15'h7FFF);
    send_seq('{8'h9F, 8'h7F, 8'h7F});

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      pick_config();
      no_idle   = ($urandom_range(0, 3) == 0);
      phase_end = sent_bytes + PHASE_BYTES;
      while (sent_bytes < phase_end) begin
        pick = $urandom_range(0, 19);
        if (pick < 16)
          send_packet(1'b0);
        else if (pick < 18)
          send_packet(1'b1);
        else
          send_byte(8'($urandom));
      end
    end

    drain();
    if (sb.errors == 0 && sb.reports.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
